// File: hw/rtl/bass_beat_detector_level_meter_defines.svh
// Assertion macros for the beat detector / level meter checker.
// Macros expect clk and rst_n in scope of the using module.
`ifndef BASS_BEAT_DETECTOR_LEVEL_METER_DEFINES_SVH
`define BASS_BEAT_DETECTOR_LEVEL_METER_DEFINES_SVH

// same-cycle implication
`define BBDLM_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BBDLM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/bbdlm_pkg.sv
// Package for the bass beat detector / level meter: beat and config types,
// register and sequencer codes, fixed-point constants. No dependencies.
`default_nettype none

package bbdlm_pkg;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [23:0]        bass_tone_a;
    logic [23:0]        bass_tone_b;
    logic signed [15:0] peak_low_db;
    logic signed [15:0] peak_mid_db;
    logic signed [15:0] peak_high_db;
    logic               audio_stopped;
    logic               update_busy;
    logic               link_connected;
  } in_beat_t;

  typedef struct packed {
    logic       beat_led;
    logic       levels_valid;
    logic [6:0] level_low;
    logic [6:0] level_mid;
    logic [6:0] level_high;
  } out_beat_t;

  typedef struct packed {
    logic [23:0] bass_min_level;
    logic [15:0] smooth_alpha;
    logic [15:0] average_alpha;
    logic [15:0] ratio_threshold;
    logic [15:0] min_beat_gap_ms;
    logic [15:0] flash_time_ms;
    logic [15:0] levels_period_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_BASS_MIN      = 3'd0,
    REG_SMOOTH_ALPHA  = 3'd1,
    REG_AVERAGE_ALPHA = 3'd2,
    REG_RATIO_THR     = 3'd3,
    REG_MIN_GAP       = 3'd4,
    REG_FLASH_TIME    = 3'd5,
    REG_LEVELS_PERIOD = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_APPLY,
    ST_FLASH,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_SMOOTH,
    OP_AVERAGE,
    OP_DECAY_SM,
    OP_DECAY_AVG,
    OP_THR_EPS,
    OP_THR_AVG,
    OP_EASE_LOW,
    OP_EASE_MID,
    OP_EASE_HIGH,
    OP_MAP_LOW,
    OP_MAP_MID,
    OP_MAP_HIGH
  } op_t;

  localparam logic [23:0] RST_BASS_MIN      = 24'd41;
  localparam logic [15:0] RST_SMOOTH_ALPHA  = 16'd19661;
  localparam logic [15:0] RST_AVERAGE_ALPHA = 16'd655;
  localparam logic [15:0] RST_RATIO_THR     = 16'd384;
  localparam logic [15:0] RST_MIN_GAP       = 16'd200;
  localparam logic [15:0] RST_FLASH_TIME    = 16'd50;
  localparam logic [15:0] RST_LEVELS_PERIOD = 16'd50;

  localparam logic [15:0] DECAY_FAST = 16'd58982;   // 0.9
  localparam logic [15:0] DECAY_SLOW = 16'd65470;   // 0.999
  localparam logic [15:0] EASE_PEAK  = 16'd39322;   // 0.6
  localparam logic [15:0] EASE_STOP  = 16'd9830;    // 0.15
  localparam logic [31:0] EPS_Q32    = 32'd4295;    // 1e-6 in Q0.32
  // floor(y/15) = (y * 2185) >> 15 for y below 4681
  localparam logic [15:0] MAP_RECIP  = 16'd2185;
  localparam logic signed [15:0] FLOOR_DB = -16'sd15360;  // -60 dB Q7.8
  localparam logic [20:0] MAP_BIAS   = 21'd7680;
  localparam logic [48:0] ROUND_HALF = 49'd32768;

endpackage

`default_nettype wire

// File: hw/rtl/bbdlm_regs.sv
// APB-style configuration register file for the beat detector / level meter.
// Depends on bbdlm_pkg (cfg_t, reg_idx_t, reset values).
`default_nettype none

module bbdlm_regs
  import bbdlm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bass_min_level   <= RST_BASS_MIN;
      cfg_r.smooth_alpha     <= RST_SMOOTH_ALPHA;
      cfg_r.average_alpha    <= RST_AVERAGE_ALPHA;
      cfg_r.ratio_threshold  <= RST_RATIO_THR;
      cfg_r.min_beat_gap_ms  <= RST_MIN_GAP;
      cfg_r.flash_time_ms    <= RST_FLASH_TIME;
      cfg_r.levels_period_ms <= RST_LEVELS_PERIOD;
    end else if (wr_en) begin
      case (idx)
        REG_BASS_MIN:      cfg_r.bass_min_level   <= pwdata[23:0];
        REG_SMOOTH_ALPHA:  cfg_r.smooth_alpha     <= pwdata[15:0];
        REG_AVERAGE_ALPHA: cfg_r.average_alpha    <= pwdata[15:0];
        REG_RATIO_THR:     cfg_r.ratio_threshold  <= pwdata[15:0];
        REG_MIN_GAP:       cfg_r.min_beat_gap_ms  <= pwdata[15:0];
        REG_FLASH_TIME:    cfg_r.flash_time_ms    <= pwdata[15:0];
        REG_LEVELS_PERIOD: cfg_r.levels_period_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASS_MIN:      prdata = {8'd0, cfg_r.bass_min_level};
      REG_SMOOTH_ALPHA:  prdata = {16'd0, cfg_r.smooth_alpha};
      REG_AVERAGE_ALPHA: prdata = {16'd0, cfg_r.average_alpha};
      REG_RATIO_THR:     prdata = {16'd0, cfg_r.ratio_threshold};
      REG_MIN_GAP:       prdata = {16'd0, cfg_r.min_beat_gap_ms};
      REG_FLASH_TIME:    prdata = {16'd0, cfg_r.flash_time_ms};
      REG_LEVELS_PERIOD: prdata = {16'd0, cfg_r.levels_period_ms};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bbdlm_mul.sv
// Shared 32x16 unsigned multiplier with registered product.
// Depends on bbdlm_pkg only by convention; no types used.
`default_nettype none

module bbdlm_mul
  import bbdlm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [15:0] b,
  output logic      [47:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {16'd0, a} * {32'd0, b};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bass_beat_detector_level_meter.sv
// Bass beat detector and three-band level meter, one shared 32x16 multiplier.
// Each product goes through an issue state and an apply state. Worst-case tick: 4 bass
// products, the flash/period state, 3 ease and 3 map products, then the output state. A new
// beat is taken only once back in idle, after the result is loaded, which out_stall can hold off.
// Busy ticks go straight to the output state. Decay-only or no-level ticks are shorter.
// rst_n (sync): config to defaults, meters to -60 dB, control state cleared; payloads not reset.
`default_nettype none

module bass_beat_detector_level_meter
  import bbdlm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t   cfg;
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  in_beat_t  in_r;
  out_beat_t out_data_r, out_nxt;
  logic      out_valid_r;

  logic [31:0]        sm_r, avg_r;
  logic [31:0]        last_beat_r, flash_end_r, last_levels_r;
  logic               flash_on_r, led_r, fresh_r, neg_r;
  logic signed [15:0] m_low_r, m_mid_r, m_high_r;
  logic [8:0]         eh_r;
  logic [6:0]         pos_low_r, pos_mid_r, pos_high_r;

  logic        in_accept, mul_en, out_load, neg_nxt;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod_r;

  logic [24:0] in_bass, r_bass;
  logic        in_bass_ok;
  logic [31:0] u_base, u_tgt, u_mag;
  logic        u_neg;
  logic signed [15:0] m_sel, peak_sel, m_tgt, m_clamp;
  logic signed [16:0] m_diff;
  logic [16:0] m_mag17;
  logic [15:0] x16;
  logic [20:0] y21;
  logic [48:0] rnd_sum;
  logic [32:0] rnd;
  logic [31:0] sm_step, avg_step;
  logic [15:0] m_step;
  logic        beat_hit, gap_ok, levels_due, flash_done;
  logic [31:0] now_r;

  assign cfg_pready = 1'b1;

  bbdlm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  bbdlm_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign now_r     = in_r.now_ms;

  assign in_bass    = {1'b0, in_data.bass_tone_a} + {1'b0, in_data.bass_tone_b};
  assign r_bass     = {1'b0, in_r.bass_tone_a} + {1'b0, in_r.bass_tone_b};
  assign in_bass_ok = in_bass >= {1'b0, cfg.bass_min_level};

  // operand selection for the op being issued
  always_comb begin
    u_base = (op_r == OP_AVERAGE) ? avg_r : sm_r;
    u_tgt  = (op_r == OP_AVERAGE) ? sm_r : {7'd0, r_bass};
    u_neg  = u_tgt < u_base;
    u_mag  = u_neg ? (u_base - u_tgt) : (u_tgt - u_base);

    if (op_r inside {OP_EASE_LOW, OP_MAP_LOW}) begin
      m_sel    = m_low_r;
      peak_sel = in_r.peak_low_db;
    end else if (op_r inside {OP_EASE_MID, OP_MAP_MID}) begin
      m_sel    = m_mid_r;
      peak_sel = in_r.peak_mid_db;
    end else begin
      m_sel    = m_high_r;
      peak_sel = in_r.peak_high_db;
    end
    m_tgt   = in_r.audio_stopped ? FLOOR_DB : peak_sel;
    m_diff  = {m_tgt[15], m_tgt} - {m_sel[15], m_sel};
    m_mag17 = m_diff[16] ? (17'd0 - m_diff) : m_diff;

    if (m_sel < FLOOR_DB) begin
      m_clamp = FLOOR_DB;
    end else if (m_sel > 16'sd0) begin
      m_clamp = 16'sd0;
    end else begin
      m_clamp = m_sel;
    end
    x16 = m_clamp - FLOOR_DB;
    // x*100 + half of 15360, then /1024; the /15 goes through the multiplier
    y21 = ({7'd0, x16[13:0]} << 6) + ({7'd0, x16[13:0]} << 5)
        + ({7'd0, x16[13:0]} << 2) + MAP_BIAS;

    mul_a   = 32'd0;
    mul_b   = 16'd0;
    neg_nxt = 1'b0;
    case (op_r)
      OP_SMOOTH: begin
        mul_a = u_mag; mul_b = cfg.smooth_alpha; neg_nxt = u_neg;
      end
      OP_AVERAGE: begin
        mul_a = u_mag; mul_b = cfg.average_alpha; neg_nxt = u_neg;
      end
      OP_DECAY_SM: begin
        mul_a = sm_r; mul_b = DECAY_FAST;
      end
      OP_DECAY_AVG: begin
        mul_a = avg_r; mul_b = DECAY_SLOW;
      end
      OP_THR_EPS: begin
        mul_a = EPS_Q32; mul_b = cfg.ratio_threshold;
      end
      OP_THR_AVG: begin
        mul_a = avg_r; mul_b = cfg.ratio_threshold;
      end
      OP_EASE_LOW, OP_EASE_MID, OP_EASE_HIGH: begin
        mul_a   = {16'd0, m_mag17[15:0]};
        mul_b   = in_r.audio_stopped ? EASE_STOP : EASE_PEAK;
        neg_nxt = m_diff[16];
      end
      OP_MAP_LOW, OP_MAP_MID, OP_MAP_HIGH: begin
        mul_a = {21'd0, y21[20:10]}; mul_b = MAP_RECIP;
      end
      default: ;
    endcase
  end

  // apply side: round half away from zero, done on the magnitude
  assign rnd_sum  = {1'b0, prod_r} + ROUND_HALF;
  assign rnd      = rnd_sum[48:16];
  assign sm_step  = neg_r ? (sm_r - rnd[31:0]) : (sm_r + rnd[31:0]);
  assign avg_step = neg_r ? (avg_r - rnd[31:0]) : (avg_r + rnd[31:0]);
  assign m_step   = neg_r ? ($unsigned(m_sel) - rnd[15:0]) : ($unsigned(m_sel) + rnd[15:0]);

  // (sm << 28) > thr*((avg << 20) + eps)  <=>  (sm << 8) > thr*avg + (thr*eps >> 20)
  assign beat_hit   = {9'd0, sm_r, 8'd0} > ({1'b0, prod_r} + {40'd0, eh_r});
  assign gap_ok     = (now_r - last_beat_r) > {16'd0, cfg.min_beat_gap_ms};
  assign levels_due = (now_r - last_levels_r) >= {16'd0, cfg.levels_period_ms};
  assign flash_done = flash_on_r && (now_r >= flash_end_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.update_busy) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ISSUE;
            op_nxt    = in_bass_ok ? OP_SMOOTH : OP_DECAY_SM;
          end
        end
      end
      ST_ISSUE: state_nxt = ST_APPLY;
      ST_APPLY: begin
        state_nxt = ST_ISSUE;
        case (op_r)
          OP_SMOOTH:    op_nxt = OP_AVERAGE;
          OP_AVERAGE: begin
            if (avg_step != 32'd0) begin
              op_nxt = OP_THR_EPS;
            end else begin
              state_nxt = ST_FLASH;
            end
          end
          OP_THR_EPS:   op_nxt = OP_THR_AVG;
          OP_DECAY_SM:  op_nxt = OP_DECAY_AVG;
          OP_THR_AVG,
          OP_DECAY_AVG: state_nxt = ST_FLASH;
          OP_EASE_LOW:  op_nxt = OP_EASE_MID;
          OP_EASE_MID:  op_nxt = OP_EASE_HIGH;
          OP_EASE_HIGH: begin
            if (fresh_r) begin
              op_nxt = OP_MAP_LOW;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_MAP_LOW:   op_nxt = OP_MAP_MID;
          OP_MAP_MID:   op_nxt = OP_MAP_HIGH;
          default:      state_nxt = ST_DONE;
        endcase
      end
      ST_FLASH: begin
        if (levels_due) begin
          state_nxt = ST_ISSUE;
          op_nxt    = OP_EASE_LOW;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    mul_en   = (state_r == ST_ISSUE);
    out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    out_nxt.beat_led     = led_r;
    out_nxt.levels_valid = fresh_r;
    out_nxt.level_low    = fresh_r ? pos_low_r : 7'd0;
    out_nxt.level_mid    = fresh_r ? pos_mid_r : 7'd0;
    out_nxt.level_high   = fresh_r ? pos_high_r : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_SMOOTH;
      out_valid_r   <= 1'b0;
      sm_r          <= 32'd0;
      avg_r         <= 32'd0;
      last_beat_r   <= 32'd0;
      flash_end_r   <= 32'd0;
      last_levels_r <= 32'd0;
      flash_on_r    <= 1'b0;
      led_r         <= 1'b0;
      fresh_r       <= 1'b0;
      m_low_r       <= FLOOR_DB;
      m_mid_r       <= FLOOR_DB;
      m_high_r      <= FLOOR_DB;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (in_accept) begin
        fresh_r <= 1'b0;
        if (in_data.update_busy) begin
          led_r <= 1'b0;
        end
      end

      if (state_r == ST_APPLY) begin
        case (op_r)
          OP_SMOOTH:    sm_r  <= sm_step;
          OP_AVERAGE:   avg_r <= avg_step;
          OP_DECAY_SM:  sm_r  <= prod_r[47:16];
          OP_DECAY_AVG: avg_r <= prod_r[47:16];
          OP_THR_AVG: begin
            if (beat_hit && gap_ok) begin
              led_r       <= 1'b1;
              flash_on_r  <= 1'b1;
              flash_end_r <= now_r + {16'd0, cfg.flash_time_ms};
              last_beat_r <= now_r;
            end
          end
          OP_EASE_LOW:  m_low_r  <= signed'(m_step);
          OP_EASE_MID:  m_mid_r  <= signed'(m_step);
          OP_EASE_HIGH: m_high_r <= signed'(m_step);
          default: ;
        endcase
      end

      if (state_r == ST_FLASH) begin
        if (flash_done) begin
          led_r      <= 1'b0;
          flash_on_r <= 1'b0;
        end
        if (levels_due) begin
          last_levels_r <= now_r;
          fresh_r       <= in_r.link_connected;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
    if (state_r == ST_ISSUE) begin
      neg_r <= neg_nxt;
    end
    if (state_r == ST_APPLY) begin
      case (op_r)
        OP_THR_EPS:  eh_r       <= prod_r[28:20];
        OP_MAP_LOW:  pos_low_r  <= prod_r[21:15];
        OP_MAP_MID:  pos_mid_r  <= prod_r[21:15];
        OP_MAP_HIGH: pos_high_r <= prod_r[21:15];
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bbdlm_checker.sv
// Port-level checker for the beat detector / level meter, bound to the top.
// Depends on bbdlm_pkg and bass_beat_detector_level_meter_defines.svh.
`default_nettype none
`include "bass_beat_detector_level_meter_defines.svh"

module bbdlm_checker
  import bbdlm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_data
);

  // one tick in flight: after a beat is taken the input side stalls
  `BBDLM_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "beat accepted while busy")

  `BBDLM_ASSERT_NOW(a_levels_zero, out_valid && !out_data.levels_valid, out_data.level_low == 7'd0 && out_data.level_mid == 7'd0 && out_data.level_high == 7'd0, "levels set without levels_valid")

  `BBDLM_ASSERT_NOW(a_levels_range, out_valid, out_data.level_low <= 7'd100 && out_data.level_mid <= 7'd100 && out_data.level_high <= 7'd100, "level beyond 100")

  `BBDLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind bass_beat_detector_level_meter bbdlm_checker u_bbdlm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
